/* src/bdc_pkg.sv */
// Shared types and constants for the UART baud divisor calculator.
package bdc_pkg;

  // Width of the dividend 25 * pclk and of the quotient.
  localparam int NUM_W = 29;
  // Width of the divisor k * baud_rate.
  localparam int DEN_W = 26;
  // One quotient bit is produced in each divider stage.
  localparam int DIV_STEPS = NUM_W;
  // Mantissa width, including room for the rounding carry.
  localparam int MANT_W = 23;
  // Reciprocal of 100 scaled by 2^RECIP_SHIFT; exact for dividends below 2^30.
  localparam int RECIP_SHIFT = 35;
  localparam logic [NUM_W-1:0] RECIP_100 = 29'd343597384;
  localparam int PROD_W = 2 * NUM_W;
  // Largest mantissa the divisor word can hold.
  localparam logic [MANT_W-1:0] MANT_MAX = 23'd4095;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAUD_ZERO = 2'd1;
  localparam logic [1:0] STATUS_SATURATED = 2'd2;

  // Request word.
  typedef struct packed {
    logic [31:0] clock_cfg;
    logic        fast_bus;
    logic        oversample_by_8;
    logic [23:0] baud_rate;
  } req_t;

  // Response word.
  typedef struct packed {
    logic [15:0] divisor_word;
    logic [1:0]  status;
  } rsp_t;

  // Working data of one divider stage.
  typedef struct packed {
    logic             zero_baud;
    logic             over8;
    logic [DEN_W-1:0] den;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] rem;
  } div_stage_t;

endpackage

/* src/bdc_front.sv */
// Input stage: peripheral clock, dividend and divisor for the long division.
module bdc_front import bdc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  req_t       in_data,
  output logic       out_valid,
  output div_stage_t out_data
);

  logic [23:0]      sys_clk;
  logic [3:0]       ahb_shift;
  logic [2:0]       bus_code;
  logic [2:0]       bus_shift;
  logic [3:0]       total_shift;
  logic [23:0]      pclk;
  logic [NUM_W-1:0] pclk_ext;
  div_stage_t       stage_next;

  always_comb begin
    // System clock from the source select.
    case (in_data.clock_cfg[3:2])
      2'd0:    sys_clk = 24'd16000000;
      2'd1:    sys_clk = 24'd8000000;
      default: sys_clk = 24'd0;
    endcase

    // All prescalers are powers of two, so the divisions become one right shift.
    if (!in_data.clock_cfg[7]) begin
      ahb_shift = 4'd0;
    end else begin
      case (in_data.clock_cfg[6:4])
        3'd0:    ahb_shift = 4'd1;
        3'd1:    ahb_shift = 4'd2;
        3'd2:    ahb_shift = 4'd3;
        3'd3:    ahb_shift = 4'd4;
        3'd4:    ahb_shift = 4'd6;
        3'd5:    ahb_shift = 4'd7;
        3'd6:    ahb_shift = 4'd8;
        default: ahb_shift = 4'd9;
      endcase
    end

    bus_code = in_data.fast_bus ? in_data.clock_cfg[15:13] : in_data.clock_cfg[12:10];
    bus_shift = bus_code[2] ? ({1'b0, bus_code[1:0]} + 3'd1) : 3'd0;
    total_shift = ahb_shift + {1'b0, bus_shift};
    pclk = sys_clk >> total_shift;
    pclk_ext = {5'b0, pclk};

    // Dividend 25 * pclk, divisor 2 * baud (8x) or 4 * baud (16x).
    stage_next.zero_baud = (in_data.baud_rate == 24'd0);
    stage_next.over8 = in_data.oversample_by_8;
    stage_next.num = (pclk_ext << 4) + (pclk_ext << 3) + pclk_ext;
    stage_next.den = in_data.oversample_by_8 ? {1'b0, in_data.baud_rate, 1'b0}
                                             : {in_data.baud_rate, 2'b0};
    stage_next.rem = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= stage_next;
    end
  end

endmodule

/* src/bdc_div.sv */
// Pipelined restoring divider: one quotient bit per stage.
module bdc_div import bdc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  div_stage_t in_data,
  output logic       out_valid,
  output div_stage_t out_data
);

  div_stage_t stage_q [DIV_STEPS];
  logic       stage_v [DIV_STEPS];

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
    div_stage_t       src;
    logic             src_v;
    div_stage_t       step;
    logic [DEN_W:0]   trial;
    logic             fits;

    if (g == 0) begin : g_first
      assign src = in_data;
      assign src_v = in_valid;
    end else begin : g_rest
      assign src = stage_q[g-1];
      assign src_v = stage_v[g-1];
    end

    // Bring down the next dividend bit and subtract the divisor if it fits.
    always_comb begin
      trial = {src.rem, src.num[NUM_W-1]};
      fits = (trial >= {1'b0, src.den});
      step = src;
      step.rem = fits ? DEN_W'(trial - {1'b0, src.den}) : trial[DEN_W-1:0];
      step.num = {src.num[NUM_W-2:0], fits};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_v[g] <= 1'b0;
      end else if (en) begin
        stage_v[g] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stage_q[g] <= step;
      end
    end
  end

  assign out_valid = stage_v[DIV_STEPS-1];
  assign out_data = stage_q[DIV_STEPS-1];

endmodule

/* src/bdc_post.sv */
// Mantissa split, fraction rounding and saturation, in three stages.
module bdc_post import bdc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  div_stage_t in_data,
  output logic       out_valid,
  output rsp_t       out_data
);

  // Stage A: quotient and its product with the reciprocal of 100.
  logic              a_valid;
  logic              a_zero;
  logic              a_over8;
  logic [NUM_W-1:0]  a_quot;
  logic [PROD_W-1:0] a_prod;

  // Stage B: mantissa and remainder.
  logic              b_valid;
  logic              b_zero;
  logic              b_over8;
  logic [MANT_W-1:0] b_mant;
  logic [6:0]        b_rem;

  logic [MANT_W-1:0] mant_q;
  logic [6:0]        mant_x100_low;
  logic [10:0]       frac_num;
  logic [23:0]       frac_prod;
  logic [4:0]        frac;
  logic [4:0]        frac_one;
  logic [MANT_W-1:0] mant_c;
  logic [4:0]        frac_c;
  rsp_t              rsp_next;

  // Remainder below 100, so seven low bits of the difference suffice.
  assign mant_q = a_prod[PROD_W-1:RECIP_SHIFT];
  assign mant_x100_low = 7'((mant_q << 6) + (mant_q << 5) + (mant_q << 2));

  always_comb begin
    // Rounded fraction (rem * one + 50) / 100 via reciprocal 5243 / 2^19.
    frac_one = b_over8 ? 5'd8 : 5'd16;
    frac_num = (b_over8 ? {1'b0, b_rem, 3'b0} : {b_rem, 4'b0}) + 11'd50;
    frac_prod = {13'b0, frac_num} * 24'd5243;
    frac = frac_prod[23:19];

    // Rounding up to a whole unit carries into the mantissa.
    if (frac == frac_one) begin
      frac_c = 5'd0;
      mant_c = b_mant + MANT_W'(1);
    end else begin
      frac_c = frac;
      mant_c = b_mant;
    end

    if (b_zero) begin
      rsp_next.divisor_word = 16'd0;
      rsp_next.status = STATUS_BAUD_ZERO;
    end else if (mant_c > MANT_MAX) begin
      rsp_next.divisor_word = {MANT_MAX[11:0], frac_one[3:0] - 4'd1};
      rsp_next.status = STATUS_SATURATED;
    end else begin
      rsp_next.divisor_word = {mant_c[11:0], frac_c[3:0]};
      rsp_next.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_zero <= in_data.zero_baud;
      a_over8 <= in_data.over8;
      a_quot <= in_data.num;
      a_prod <= {{NUM_W{1'b0}}, in_data.num} * {{NUM_W{1'b0}}, RECIP_100};
      b_zero <= a_zero;
      b_over8 <= a_over8;
      b_mant <= mant_q;
      b_rem <= a_quot[6:0] - mant_x100_low;
      out_data <= rsp_next;
    end
  end

endmodule

/* src/uart_baud_divisor_calculator.sv */
// Top level of the UART baud divisor calculator: pipeline and output buffer.
//
// Request channel: req carries clock_cfg, fast_bus, oversample_by_8 and
// baud_rate; a word is taken at a rising edge with req_valid high and
// req_stall low. Response channel: rsp carries divisor_word and status; a word
// is taken at a rising edge with rsp_valid high and rsp_stall low.
// Every request word yields exactly one response word, in order.
// The word passes one input stage (loaded at the accepting edge), 29 divider
// stages (one quotient bit each), three stages for mantissa, fraction and
// saturation, and the output register. Throughput is one word per cycle
// while req_stall is low. The length of the divider pipeline is set by the
// 29-bit quotient.
// Reset (synchronous, active high) empties the pipeline and the output buffer.
// When the receiver stalls, one further word lands in a skid register; the
// whole pipeline then holds and req_stall is raised until the skid register
// drains into the output register.
module uart_baud_divisor_calculator import bdc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic       en;
  logic       front_valid;
  div_stage_t front_data;
  logic       div_valid;
  div_stage_t div_data;
  logic       post_valid;
  rsp_t       post_data;

  logic       out_valid;
  rsp_t       out_data;
  logic       skid_valid;
  rsp_t       skid_data;
  logic       take;

  // The pipeline advances whenever the skid register is empty.
  assign en = !skid_valid;
  assign req_stall = skid_valid;
  assign take = out_valid && !rsp_stall;

  bdc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (req_valid),
    .in_data   (req),
    .out_valid (front_valid),
    .out_data  (front_data)
  );

  bdc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .in_data   (front_data),
    .out_valid (div_valid),
    .out_data  (div_data)
  );

  bdc_post u_post (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_valid),
    .in_data   (div_data),
    .out_valid (post_valid),
    .out_data  (post_data)
  );

  // Output register with a one-word skid buffer behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_valid <= 1'b1;
        out_data <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || take) begin
      out_valid <= post_valid;
      out_data <= post_data;
    end else if (post_valid) begin
      skid_valid <= 1'b1;
      skid_data <= post_data;
    end
  end

  assign rsp_valid = out_valid;
  assign rsp = out_data;

endmodule
